// ===== rtl/scht_pkg.sv =====
package scht_pkg;

  localparam int unsigned TableSizeDefault  = 256;
  localparam int unsigned PoolDepthDefault  = 1024;
  localparam int unsigned HandleBitsDefault = 16;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] STATUS_POOL_FULL = 2'd2;

  // datapath operations chosen by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_CLEAR,
    OP_RD_HEAD,
    OP_RD_NODE,
    OP_STEP,
    OP_RD_FREE,
    OP_INS_NODE,
    OP_INS_LINK,
    OP_REM_LINK,
    OP_REM_FREE,
    OP_DONE
  } op_e;

  // datapath status back to the controller
  typedef struct packed {
    logic clear_last;
    logic pool_empty;
    logic cur_nil;
    logic key_eq;
    logic key_gt;
  } dp_status_t;

endpackage

// ===== rtl/scht_ctrl.sv =====
module scht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  scht_pkg::cmd_e      cmd_i,
  input  scht_pkg::dp_status_t st_i,
  output scht_pkg::op_e       op_o,
  output logic                busy_o
);
  import scht_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_HEAD  = 11'b00000000100,
    S_NODE  = 11'b00000001000,
    S_EVAL  = 11'b00000010000,
    S_FREE  = 11'b00000100000,
    S_INSN  = 11'b00001000000,
    S_INSL  = 11'b00010000000,
    S_REML  = 11'b00100000000,
    S_REMF  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;
  op_e    op;

  // next state and datapath operation
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    op      = OP_IDLE;
    unique case (state_q)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          op    = OP_CAPTURE;
          cmd_d = cmd_i;
          if (cmd_i == CMD_NONE) state_d = S_DONE;
          else state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        op = OP_RD_HEAD;
        if (cmd_q == CMD_INSERT) state_d = S_FREE;
        else state_d = S_NODE;
      end
      S_FREE: begin
        op = OP_RD_FREE;
        if (st_i.pool_empty) state_d = S_DONE;
        else state_d = S_NODE;
      end
      S_NODE: begin
        op = OP_RD_NODE;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (st_i.cur_nil) begin
          if (cmd_q == CMD_INSERT) state_d = S_INSN;
          else state_d = S_DONE;
        end else if (st_i.key_eq) begin
          if (cmd_q == CMD_INSERT) begin
            op = OP_STEP;
            state_d = S_INSN;
          end else if (cmd_q == CMD_REMOVE) state_d = S_REML;
          else state_d = S_DONE;
        end else if (st_i.key_gt && cmd_q == CMD_INSERT) begin
          state_d = S_INSN;
        end else begin
          op = OP_STEP;
          state_d = S_EVAL;
        end
      end
      S_INSN: begin
        op = OP_INS_NODE;
        state_d = S_INSL;
      end
      S_INSL: begin
        op = OP_INS_LINK;
        state_d = S_DONE;
      end
      S_REML: begin
        op = OP_REM_LINK;
        state_d = S_REMF;
      end
      S_REMF: begin
        op = OP_REM_FREE;
        state_d = S_DONE;
      end
      S_DONE: begin
        op = OP_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cmd_q   <= CMD_NONE;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
    end
  end

  assign op_o   = op;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/scht_dp.sv =====
module scht_dp #(
  parameter int unsigned TableSize  = scht_pkg::TableSizeDefault,
  parameter int unsigned PoolDepth  = scht_pkg::PoolDepthDefault,
  parameter int unsigned HandleBits = scht_pkg::HandleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scht_pkg::op_e                 op_i,
  input  logic [scht_pkg::CmdW-1:0]     cmd_i,
  input  logic [scht_pkg::KeyW-1:0]     key_i,
  input  logic [scht_pkg::HandleW-1:0]  handle_i,
  output scht_pkg::dp_status_t          st_o,
  output logic                          done_o,
  output logic                          found_o,
  output logic [scht_pkg::HandleW-1:0]  handle_out_o,
  output logic [scht_pkg::StatusW-1:0]  status_o
);
  import scht_pkg::*;

  localparam int unsigned BW  = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int unsigned NW  = $clog2(PoolDepth + 1);
  localparam int unsigned IW  = (PoolDepth > 1) ? $clog2(PoolDepth) : 1;
  localparam int unsigned HBW = (HandleBits < HandleW) ? HandleBits : HandleW;
  localparam int unsigned CW  = (BW > IW) ? BW : IW;
  localparam logic [NW-1:0] Nil = NW'(PoolDepth);

  // node and bucket stores
  logic [NW-1:0]      head_mem [TableSize];
  logic [NW-1:0]      next_mem [PoolDepth];
  logic [KeyW-1:0]    key_mem  [PoolDepth];
  logic [HandleW-1:0] hdl_mem  [PoolDepth];

  logic [CmdW-1:0]    cmd_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] hdl_q;
  logic [BW-1:0]      bkt_q;
  logic [NW-1:0]      prev_q, cur_q, free_q, new_q;
  logic [KeyW-1:0]    ckey_q;
  logic [HandleW-1:0] chdl_q;
  logic [NW-1:0]      cnext_q, pnext_q;
  logic [CW:0]        clr_q;
  logic               found_q, done_q;
  logic [HandleW-1:0] hout_q;
  logic [StatusW-1:0] status_q;
  logic [BW-1:0]      bkt_in;
  logic [IW-1:0]      cur_idx, free_idx, new_idx, prev_idx;

  assign bkt_in   = BW'(key_i % TableSize);
  assign cur_idx  = cur_q[IW-1:0];
  assign free_idx = free_q[IW-1:0];
  assign new_idx  = new_q[IW-1:0];
  assign prev_idx = prev_q[IW-1:0];

  assign st_o.clear_last = (clr_q >= (CW+1)'(((TableSize > PoolDepth) ? TableSize
                                               : PoolDepth) - 1));
  assign st_o.pool_empty = (free_q == Nil);
  assign st_o.cur_nil    = (cur_q == Nil);
  assign st_o.key_eq     = (ckey_q == key_q);
  assign st_o.key_gt     = (ckey_q > key_q);

  // memory writes and registered reads
  always_ff @(posedge clk_i) begin
    unique case (op_i) inside
      OP_CLEAR: begin
        if (clr_q < (CW+1)'(TableSize)) head_mem[clr_q[BW-1:0]] <= Nil;
        if (clr_q < (CW+1)'(PoolDepth)) next_mem[clr_q[IW-1:0]] <= NW'(clr_q) + NW'(1);
      end
      OP_RD_NODE, OP_STEP: begin
        if (op_i == OP_STEP ? (cnext_q != Nil) : (cur_q != Nil)) begin
          ckey_q  <= key_mem[op_i == OP_STEP ? cnext_q[IW-1:0] : cur_idx];
          chdl_q  <= hdl_mem[op_i == OP_STEP ? cnext_q[IW-1:0] : cur_idx];
          cnext_q <= next_mem[op_i == OP_STEP ? cnext_q[IW-1:0] : cur_idx];
        end
      end
      OP_RD_FREE: pnext_q <= next_mem[free_idx];
      OP_INS_NODE: begin
        // the walk stops with cur on the node that follows the new one
        key_mem[new_idx]  <= key_q;
        hdl_mem[new_idx]  <= hdl_q;
        next_mem[new_idx] <= cur_q;
      end
      OP_INS_LINK: begin
        if (prev_q == Nil) head_mem[bkt_q] <= new_q;
        else next_mem[prev_idx] <= new_q;
      end
      OP_REM_LINK: begin
        if (prev_q == Nil) head_mem[bkt_q] <= cnext_q;
        else next_mem[prev_idx] <= cnext_q;
      end
      OP_REM_FREE: next_mem[cur_idx] <= free_q;
      default: ;
    endcase
  end

  // walk pointers and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      prev_q   <= Nil;
      cur_q    <= Nil;
      free_q   <= '0;
      new_q    <= Nil;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      hout_q   <= '0;
      status_q <= STATUS_OK;
      cmd_q    <= '0;
      key_q    <= '0;
      hdl_q    <= '0;
      bkt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (op_i)
        OP_CLEAR: clr_q <= clr_q + 1'b1;
        OP_CAPTURE: begin
          cmd_q    <= cmd_i;
          key_q    <= key_i;
          hdl_q    <= handle_i & HandleW'((17'h1 << HBW) - 17'h1);
          bkt_q    <= bkt_in;
          prev_q   <= Nil;
          found_q  <= 1'b0;
          hout_q   <= '0;
          status_q <= STATUS_OK;
        end
        OP_RD_HEAD: cur_q <= head_mem[bkt_q];
        OP_RD_FREE: begin
          if (free_q == Nil) status_q <= STATUS_POOL_FULL;
          new_q <= free_q;
        end
        OP_STEP: begin
          prev_q <= cur_q;
          cur_q  <= cnext_q;
        end
        OP_INS_NODE: free_q <= pnext_q;
        OP_REM_FREE: free_q <= cur_q;
        OP_DONE: begin
          done_q <= 1'b1;
          if (cmd_q == CMD_REMOVE || cmd_q == CMD_LOOKUP) begin
            if (cur_q != Nil && ckey_q == key_q) begin
              found_q <= 1'b1;
              if (cmd_q == CMD_LOOKUP) hout_q <= chdl_q;
            end else begin
              status_q <= STATUS_NOT_FOUND;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign handle_out_o = hout_q;
  assign status_o     = status_q;

endmodule

// ===== rtl/sorted_chain_hash_table_core.sv =====
// channel  | ports                          | handshake
// command  | cmd_i, key_i, handle_i         | start_i high while busy_o low
// result   | found_o, handle_out_o, status_o | done_o high for one cycle
//
// a command reads its bucket head and walks the chain; insert first takes a
// free node and ends early on an empty pool, an unused command goes straight
// to the result; busy_o drops in the cycle the result shows.
// reset: a clearing pass over every bucket and pool node sets empty buckets
// and the free list; busy_o is high.
// the receiver cannot stall; each word is shown once with done_o.
module sorted_chain_hash_table_core #(
  parameter int unsigned TableSize  = scht_pkg::TableSizeDefault,
  parameter int unsigned PoolDepth  = scht_pkg::PoolDepthDefault,
  parameter int unsigned HandleBits = scht_pkg::HandleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [scht_pkg::CmdW-1:0]     cmd_i,
  input  logic [scht_pkg::KeyW-1:0]     key_i,
  input  logic [scht_pkg::HandleW-1:0]  handle_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [scht_pkg::HandleW-1:0]  handle_out_o,
  output logic [scht_pkg::StatusW-1:0]  status_o
);
  import scht_pkg::*;

  op_e        op;
  dp_status_t st;
  logic       busy;

  // controller
  scht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_e'(cmd_i)),
    .st_i   (st),
    .op_o   (op),
    .busy_o (busy)
  );

  // datapath
  scht_dp #(
    .TableSize (TableSize),
    .PoolDepth (PoolDepth),
    .HandleBits(HandleBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .handle_i    (handle_i),
    .st_o        (st),
    .done_o      (done_o),
    .found_o     (found_o),
    .handle_out_o(handle_out_o),
    .status_o    (status_o)
  );

  assign busy_o = busy;

endmodule

// ===== rtl/scht_checker.sv =====
module scht_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic                          found_o,
  input logic [scht_pkg::HandleW-1:0]  handle_out_o,
  input logic [scht_pkg::StatusW-1:0]  status_o
);
  import scht_pkg::*;

  // accepted word raises busy next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("busy not raised");

  // results only after a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without command");

  // found and status agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == STATUS_OK)) else $error("found with error");

  // handle only with found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (handle_out_o == '0)) else $error("stray handle");

endmodule

bind sorted_chain_hash_table_core scht_checker u_chk (.*);
